// File: src/mwsl_pkg.sv
// ----------------------------------------------------------------------------
// mwsl_pkg
// Shared widths, register map and divider interface types for the mecanum
// wheel speed limiter.
// ----------------------------------------------------------------------------
package mwsl_pkg;

  localparam int unsigned WHEEL_COUNT = 4;
  localparam int unsigned WHEEL_IDX_W = $clog2(WHEEL_COUNT);

  // field and register widths
  localparam int unsigned VEL_W    = 16;
  localparam int unsigned WHEEL_W  = 24;
  localparam int unsigned CFG16_W  = 16;
  localparam int unsigned LIMIT_W  = 23;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;

  // datapath widths
  localparam int unsigned SUM_W    = 34;              // signed Q.24 wheel sum
  localparam int unsigned MAG_W    = SUM_W - 1;       // magnitude of a sum
  localparam int unsigned MUL_A_W  = MAG_W;
  localparam int unsigned MUL_B_W  = LIMIT_W;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned WSHIFT   = 22;              // Q.32 to Q13.10
  localparam int unsigned VSHIFT   = 14;              // Q5.10 to Q.24

  // divider geometry: quotient never reaches the limit width
  localparam int unsigned DIV_SOR_W = WHEEL_W;
  localparam int unsigned DIV_QUO_W = LIMIT_W;
  localparam int unsigned DIV_END_W = DIV_SOR_W + DIV_QUO_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_QUO_W + 1);

  // register map, word index
  localparam logic [1:0] REG_WHEELBASE = 2'd0;
  localparam logic [1:0] REG_INV_RADIUS = 2'd1;
  localparam logic [1:0] REG_MAX_SPEED = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  // reset values
  localparam logic [CFG16_W-1:0] WHEELBASE_RST  = 16'd8192;
  localparam logic [CFG16_W-1:0] INV_RADIUS_RST = 16'd3413;
  localparam logic [LIMIT_W-1:0] MAX_SPEED_RST  = 23'd10240;
  localparam logic [CFG16_W-1:0] TIMEOUT_RST    = 16'd50;

  typedef struct packed {
    logic                 start;
    logic [DIV_END_W-1:0] dividend;
    logic [DIV_SOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: src/mwsl_div.sv
// ----------------------------------------------------------------------------
// mwsl_div
// Restoring radix-2 divider, one quotient bit per cycle. The upper part of
// the dividend must be below the divisor, so the quotient fits its width.
// ----------------------------------------------------------------------------
module mwsl_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mwsl_pkg::div_req_t req_i,
  output mwsl_pkg::div_rsp_t rsp_o
);
  import mwsl_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_SOR_W-1:0] rem_q;
  logic [DIV_SOR_W-1:0] sor_q;
  logic [DIV_QUO_W-1:0] low_q;
  logic [DIV_QUO_W-1:0] quo_q;

  logic [DIV_SOR_W+1:0] trial;
  logic                 take;

  // trial subtraction of the shifted remainder
  always_comb begin
    trial = {1'b0, rem_q, low_q[DIV_QUO_W-1]} - {2'b00, sor_q};
    take  = !trial[DIV_SOR_W+1];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend[DIV_END_W-1:DIV_QUO_W];
      low_q <= req_i.dividend[DIV_QUO_W-1:0];
      sor_q <= req_i.divisor;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? trial[DIV_SOR_W-1:0] : {rem_q[DIV_SOR_W-2:0], low_q[DIV_QUO_W-1]};
      low_q <= {low_q[DIV_QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[DIV_QUO_W-2:0], take};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: src/mecanum_wheel_speed_limiter.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_limiter
// Mecanum inverse kinematics with proportional wheel speed limiting and an
// idle tick watchdog.
// ----------------------------------------------------------------------------
// A request is either a body velocity command (mode 0) or a control tick
// (mode 1); each yields one result with the four stored wheel setpoints.
// The block takes one request at a time and holds in_stall_o high until it
// has handed its result to the output register. A command uses one shared
// 33x23 multiplier to form the yaw term and then each wheel product in turn.
// When the largest wheel exceeds max_wheel_speed, each of the four wheels
// also goes through the multiplier and a one-bit-per-cycle divider. The
// output register lets the next request enter while a result waits to be
// taken.
module mecanum_wheel_speed_limiter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mwsl_pkg::APB_AW-1:0]         paddr,
  input  logic [mwsl_pkg::APB_DW-1:0]         pwdata,
  output logic [mwsl_pkg::APB_DW-1:0]         prdata,
  output logic                                pready,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                mode_i,
  input  logic signed [mwsl_pkg::VEL_W-1:0]   vel_x_i,
  input  logic signed [mwsl_pkg::VEL_W-1:0]   vel_y_i,
  input  logic signed [mwsl_pkg::VEL_W-1:0]   yaw_rate_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [mwsl_pkg::WHEEL_W-1:0] wheel_front_a_o,
  output logic signed [mwsl_pkg::WHEEL_W-1:0] wheel_front_b_o,
  output logic signed [mwsl_pkg::WHEEL_W-1:0] wheel_rear_a_o,
  output logic signed [mwsl_pkg::WHEEL_W-1:0] wheel_rear_b_o,
  output logic                                was_limited_o,
  output logic                                timed_out_o
);
  import mwsl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_YAW,
    S_AREG,
    S_WSUM,
    S_WMUL,
    S_WSAT,
    S_CHK,
    S_SMUL,
    S_DIVGO,
    S_DIVWAIT,
    S_FIN
  } state_e;

  // configuration registers
  logic [CFG16_W-1:0] wheelbase_q;
  logic [CFG16_W-1:0] inv_radius_q;
  logic [LIMIT_W-1:0] max_speed_q;
  logic [CFG16_W-1:0] timeout_q;

  // sequencer and datapath state
  state_e                   state_q;
  logic [WHEEL_IDX_W-1:0]   k_q;
  logic [CFG16_W-1:0]       idle_q;
  logic                     cmd_q;
  logic                     lim_q;
  logic                     tmo_q;
  logic                     out_valid_q;
  logic signed [VEL_W-1:0]  vx_q;
  logic signed [VEL_W-1:0]  vy_q;
  logic signed [VEL_W-1:0]  yaw_q;
  logic signed [SUM_W-1:0]  a_q;
  logic [MAG_W-1:0]         mag_q;
  logic                     neg_q;
  logic [PROD_W-1:0]        prod_q;
  logic [WHEEL_W-1:0]       top_q;
  logic [WHEEL_W-1:0]       wmag_q [WHEEL_COUNT];
  logic                     wneg_q [WHEEL_COUNT];
  logic signed [WHEEL_W-1:0] sp_q  [WHEEL_COUNT];

  logic                     accept;
  logic                     slot_free;
  logic [CFG16_W-1:0]       idle_next;
  logic [VEL_W-1:0]         yaw_mag;
  logic signed [SUM_W-1:0]  x_ext;
  logic signed [SUM_W-1:0]  y_ext;
  logic signed [SUM_W-1:0]  wsum;
  logic [SUM_W-1:0]         wsum_abs;
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic [SUM_W-1:0]         hi;
  logic [WHEEL_W-1:0]       sat_mag;
  logic [WHEEL_W-1:0]       top_next;
  logic [SUM_W-1:0]         a_abs;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  // handshake
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign pready      = 1'b1;

  // register read
  always_comb begin
    case (paddr[3:2])
      REG_WHEELBASE:  prdata = APB_DW'(wheelbase_q);
      REG_INV_RADIUS: prdata = APB_DW'(inv_radius_q);
      REG_MAX_SPEED:  prdata = APB_DW'(max_speed_q);
      REG_TIMEOUT:    prdata = APB_DW'(timeout_q);
      default:        prdata = '0;
    endcase
  end

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheelbase_q  <= WHEELBASE_RST;
      inv_radius_q <= INV_RADIUS_RST;
      max_speed_q  <= MAX_SPEED_RST;
      timeout_q    <= TIMEOUT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_WHEELBASE:  wheelbase_q  <= pwdata[CFG16_W-1:0];
        REG_INV_RADIUS: inv_radius_q <= pwdata[CFG16_W-1:0];
        REG_MAX_SPEED:  max_speed_q  <= pwdata[LIMIT_W-1:0];
        REG_TIMEOUT:    timeout_q    <= pwdata[CFG16_W-1:0];
        default:        ;
      endcase
    end
  end

  // saturating idle count
  assign idle_next = (idle_q == '1) ? idle_q : idle_q + 1'b1;

  // wheel sum: +-X +-Y - A with the mecanum sign pattern
  always_comb begin
    x_ext = SUM_W'(vx_q) <<< VSHIFT;
    y_ext = SUM_W'(vy_q) <<< VSHIFT;
    case (k_q)
      2'd0:    wsum =  x_ext - y_ext - a_q;
      2'd1:    wsum = -x_ext - y_ext - a_q;
      2'd2:    wsum =  x_ext + y_ext - a_q;
      2'd3:    wsum = -x_ext + y_ext - a_q;
      default: wsum = '0;
    endcase
    wsum_abs = wsum[SUM_W-1] ? SUM_W'(-wsum) : SUM_W'(wsum);
    yaw_mag  = yaw_q[VEL_W-1] ? VEL_W'(-yaw_q) : VEL_W'(yaw_q);
    a_abs    = {2'b00, prod_q[2*CFG16_W-1:0]};
  end

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      S_YAW: begin
        mul_a = MUL_A_W'(yaw_mag);
        mul_b = MUL_B_W'(wheelbase_q);
      end
      S_WMUL: begin
        mul_a = mag_q;
        mul_b = MUL_B_W'(inv_radius_q);
      end
      S_SMUL: begin
        mul_a = MUL_A_W'(wmag_q[k_q]);
        mul_b = max_speed_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
  end

  // scale to Q13.10 and saturate the magnitude
  always_comb begin
    hi = prod_q[PROD_W-1:WSHIFT];
    if (neg_q) begin
      sat_mag = (hi >= SUM_W'(24'h800000)) ? 24'h800000 : hi[WHEEL_W-1:0];
    end else begin
      sat_mag = (hi > SUM_W'(24'h7FFFFF)) ? 24'h7FFFFF : hi[WHEEL_W-1:0];
    end
    top_next = (sat_mag > top_q) ? sat_mag : top_q;
  end

  // divider request
  always_comb begin
    div_req.start    = (state_q == S_DIVGO);
    div_req.dividend = prod_q[DIV_END_W-1:0];
    div_req.divisor  = top_q;
  end

  mwsl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer with its registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      idle_q      <= '0;
      cmd_q       <= 1'b0;
      lim_q       <= 1'b0;
      tmo_q       <= 1'b0;
      out_valid_q <= 1'b0;
      was_limited_o <= 1'b0;
      timed_out_o   <= 1'b0;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        sp_q[i] <= '0;
      end
    end else begin
      // result taken
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            lim_q <= 1'b0;
            if (mode_i) begin
              idle_q  <= idle_next;
              tmo_q   <= (idle_next > timeout_q);
              cmd_q   <= 1'b0;
              state_q <= S_FIN;
            end else begin
              idle_q  <= '0;
              tmo_q   <= 1'b0;
              cmd_q   <= 1'b1;
              state_q <= S_YAW;
            end
          end
        end
        S_YAW: begin
          state_q <= S_AREG;
        end
        S_AREG: begin
          k_q     <= '0;
          state_q <= S_WSUM;
        end
        S_WSUM: begin
          state_q <= S_WMUL;
        end
        S_WMUL: begin
          state_q <= S_WSAT;
        end
        S_WSAT: begin
          k_q <= k_q + 1'b1;
          if (k_q == WHEEL_IDX_W'(WHEEL_COUNT - 1)) begin
            state_q <= S_CHK;
          end else begin
            state_q <= S_WSUM;
          end
        end
        S_CHK: begin
          k_q <= '0;
          if (top_q > WHEEL_W'(max_speed_q)) begin
            lim_q   <= 1'b1;
            state_q <= S_SMUL;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_SMUL: begin
          state_q <= S_DIVGO;
        end
        S_DIVGO: begin
          state_q <= S_DIVWAIT;
        end
        S_DIVWAIT: begin
          if (div_rsp.done) begin
            k_q <= k_q + 1'b1;
            if (k_q == WHEEL_IDX_W'(WHEEL_COUNT - 1)) begin
              state_q <= S_FIN;
            end else begin
              state_q <= S_SMUL;
            end
          end
        end
        S_FIN: begin
          if (slot_free) begin
            out_valid_q   <= 1'b1;
            was_limited_o <= lim_q;
            timed_out_o   <= tmo_q;
            for (int i = 0; i < WHEEL_COUNT; i++) begin
              if (cmd_q) begin
                sp_q[i] <= wneg_q[i] ? WHEEL_W'(-wmag_q[i]) : wmag_q[i];
              end else if (tmo_q) begin
                sp_q[i] <= '0;
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          vx_q  <= vel_x_i;
          vy_q  <= vel_y_i;
          yaw_q <= yaw_rate_i;
          top_q <= '0;
        end
      end
      S_YAW: begin
        prod_q <= mul_p;
      end
      S_AREG: begin
        a_q <= yaw_q[VEL_W-1] ? SUM_W'(-a_abs) : SUM_W'(a_abs);
      end
      S_WSUM: begin
        mag_q <= wsum_abs[MAG_W-1:0];
        neg_q <= wsum[SUM_W-1];
      end
      S_WMUL: begin
        prod_q <= mul_p;
      end
      S_WSAT: begin
        wmag_q[k_q] <= sat_mag;
        wneg_q[k_q] <= neg_q && (sat_mag != '0);
        top_q       <= top_next;
      end
      S_SMUL: begin
        prod_q <= mul_p;
      end
      S_DIVWAIT: begin
        if (div_rsp.done) begin
          wmag_q[k_q] <= WHEEL_W'(div_rsp.quotient);
        end
      end
      default: ;
    endcase
  end

  // result fields
  assign wheel_front_a_o = sp_q[0];
  assign wheel_front_b_o = sp_q[1];
  assign wheel_rear_a_o  = sp_q[2];
  assign wheel_rear_b_o  = sp_q[3];

endmodule
